### rtl/spo_pkg.sv
// ----------------------------------------------------------------------------
// spo_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// sine phase oscillator.
// ----------------------------------------------------------------------------
package spo_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int STEP_BITS       = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int TIME_BITS       = 48;
  localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;

  typedef logic        [PHASE_BITS-1:0]      phase_t;
  typedef logic signed [STEP_BITS-1:0]       step_t;
  typedef logic        [TIME_BITS-1:0]       time_t;
  typedef logic signed [SAMPLE_BITS-1:0]     sample_t;
  typedef logic        [TABLE_ADDR_BITS-1:0] addr_t;
  typedef logic        [SAMPLE_BITS-1:0]     rom_word_t;
  typedef rom_word_t                         rom_t [TABLE_SIZE];

  // peak amplitude of the sine
  localparam sample_t PEAK = sample_t'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  // pi/2 in Q30 and unity in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1 << 30;

  // control that travels with one tick from the phase stage to the output
  typedef struct packed {
    logic advance;   // tick is newer than the last one taken, or none taken yet
    logic negate;    // lower half of the cycle
    logic use_peak;  // in the odd quadrant at table index zero (a quarter or three quarters)
  } lookup_ctl_t;

  // taylor divisor (2k)(2k+1) for term k
  function automatic longint unsigned taylor_div(input int k);
    longint unsigned d;
    case (k)
      1:       d = 64'd6;
      2:       d = 64'd20;
      3:       d = 64'd42;
      4:       d = 64'd72;
      5:       d = 64'd110;
      default: d = 64'd156;
    endcase
    return d;
  endfunction

  // unsigned shift and subtract division, used while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave table, evaluated at elaboration
  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) >> TABLE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = udiv64((term * x2) >> 30, taylor_div(k));
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      v = (sum * longint'(PEAK) + (ONE_Q30 / 2)) >>> 30;
      if (v > longint'(PEAK)) begin
        v = longint'(PEAK);
      end
      r[i] = rom_word_t'(v);
    end
    return r;
  endfunction

endpackage

### rtl/spo_tick_if.sv
// ----------------------------------------------------------------------------
// spo_tick_if
// Tick channel: valid/ready handshake carrying one time stamp per beat.
// ----------------------------------------------------------------------------
interface spo_tick_if;
  import spo_pkg::*;

  logic  valid;
  logic  ready;
  time_t tick_time;

  modport source (output valid, output tick_time, input ready);
  modport sink   (input valid, input tick_time, output ready);
endinterface

### rtl/spo_sample_if.sv
// ----------------------------------------------------------------------------
// spo_sample_if
// Sample channel: valid/ready handshake carrying one signed sample per beat.
// ----------------------------------------------------------------------------
interface spo_sample_if;
  import spo_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/spo_phase.sv
// ----------------------------------------------------------------------------
// spo_phase
// Phase accumulator and time stamp tracking. Decides whether an accepted
// tick advances, and forms the mirrored table address from the phase.
// ----------------------------------------------------------------------------
module spo_phase (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  spo_pkg::time_t       tick_time,
  input  spo_pkg::step_t       phase_step,
  output spo_pkg::addr_t       rom_addr,
  output spo_pkg::lookup_ctl_t ctl
);
  import spo_pkg::*;

  phase_t phase_r;
  phase_t phase_nxt;
  time_t  last_time_r;
  logic   seen_r;
  logic   advance;
  logic   [1:0] quadrant;
  addr_t  idx;

  // tick is newer than the last one, or nothing taken yet
  assign advance = !seen_r || (tick_time > last_time_r);

  // quadrant and fine index from the phase before the step
  assign quadrant = phase_r[PHASE_BITS-1 -: 2];
  assign idx      = phase_r[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  // odd quadrants read the table backwards
  assign rom_addr = quadrant[0] ? addr_t'(-idx) : idx;

  always_comb begin
    ctl.advance  = advance;
    ctl.negate   = quadrant[1];
    ctl.use_peak = quadrant[0] && (idx == '0);
  end

  // step wraps modulo one cycle, negative steps included
  assign phase_nxt = phase_r + phase_t'(phase_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      last_time_r <= '0;
      seen_r      <= 1'b0;
    end else if (accept && advance) begin
      phase_r     <= phase_nxt;
      last_time_r <= tick_time;
      seen_r      <= 1'b1;
    end
  end

endmodule

### rtl/spo_rom.sv
// ----------------------------------------------------------------------------
// spo_rom
// Quarter-wave sine table with a registered read port.
// ----------------------------------------------------------------------------
module spo_rom (
  input  logic                clk,
  input  logic                rd_en,
  input  spo_pkg::addr_t      rd_addr,
  output spo_pkg::rom_word_t  rd_data_r
);
  import spo_pkg::*;

  localparam rom_t QUARTER_SINE = build_rom();

  // synchronous read, held while stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= QUARTER_SINE[rd_addr];
    end
  end

endmodule

### rtl/spo_out.sv
// ----------------------------------------------------------------------------
// spo_out
// Lookup stage and output register. Applies the quadrant sign, substitutes
// the held sample for stale ticks and presents the result beat.
// ----------------------------------------------------------------------------
module spo_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  spo_pkg::lookup_ctl_t ctl,
  input  spo_pkg::rom_word_t   rom_data,
  input  logic                 out_ready,
  output logic                 stage_free,
  output logic                 out_valid,
  output spo_pkg::sample_t     out_sample
);
  import spo_pkg::*;

  logic        lk_valid_r;
  lookup_ctl_t lk_ctl_r;
  logic        out_valid_r;
  sample_t     out_sample_r;
  sample_t     held_r;
  logic        out_free;
  logic        lk_move;
  sample_t     mag;
  sample_t     sample_nxt;

  // pipeline flow
  assign out_free   = !out_valid_r || out_ready;
  assign lk_move    = lk_valid_r && out_free;
  assign stage_free = !lk_valid_r || out_free;

  // signed sample from table word and quadrant, or the held sample for a stale tick
  always_comb begin
    mag = lk_ctl_r.use_peak ? PEAK : sample_t'(rom_data);
    if (!lk_ctl_r.advance) begin
      sample_nxt = held_r;
    end else if (lk_ctl_r.negate) begin
      sample_nxt = -mag;
    end else begin
      sample_nxt = mag;
    end
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_valid_r <= 1'b0;
    end else if (stage_free) begin
      lk_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && stage_free) begin
      lk_ctl_r <= ctl;
    end
  end

  // output register and held sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      if (out_free) begin
        out_valid_r <= lk_valid_r;
      end
      if (lk_move) begin
        held_r <= sample_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lk_move) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

### rtl/sine_phase_oscillator_top.sv
// ----------------------------------------------------------------------------
// sine_phase_oscillator_top
// Numerically controlled sine oscillator: one sample per tick beat.
// Pipeline: an accepted tick reads the table into the registered ROM port and
// the lookup stage; its signed sample then moves into the output register.
// Throughput: 1 tick per cycle while the sample output is not stalled; the
// synchronous table read and the 32-bit phase add are each registered.
// Reset: phase zero, held sample zero, no time stamp taken, step 440 Hz/48 kHz.
// ----------------------------------------------------------------------------
module sine_phase_oscillator_top (
  input  logic           clk,
  input  logic           rst_n,
  spo_tick_if.sink       in_tick,
  spo_sample_if.source   out_sample,
  input  logic           cfg_we,
  input  spo_pkg::step_t cfg_wdata
);
  import spo_pkg::*;

  localparam step_t STEP_RESET = step_t'(39370534);

  step_t       phase_step_r;
  logic        accept;
  logic        stage_free;
  addr_t       rom_addr;
  rom_word_t   rom_data;
  lookup_ctl_t ctl;

  // step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
    end else if (cfg_we) begin
      phase_step_r <= cfg_wdata;
    end
  end

  assign in_tick.ready = stage_free;
  assign accept        = in_tick.valid && stage_free;

  spo_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .tick_time  (in_tick.tick_time),
    .phase_step (phase_step_r),
    .rom_addr   (rom_addr),
    .ctl        (ctl)
  );

  spo_rom u_rom (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (rom_addr),
    .rd_data_r (rom_data)
  );

  spo_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_tick.valid),
    .ctl        (ctl),
    .rom_data   (rom_data),
    .out_ready  (out_sample.ready),
    .stage_free (stage_free),
    .out_valid  (out_sample.valid),
    .out_sample (out_sample.sample)
  );

endmodule
